>>> design/fq15_pkg.sv
// ----------------------------------------------------------------------------
// fq15_pkg
// shared constants and control structs of the q15 fir filter
// ----------------------------------------------------------------------------
`default_nettype none

package fq15_pkg;

  localparam int TAPS      = 32;
  localparam int IDX_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 32;
  localparam int SHIFT_W   = 5;
  localparam int CIDX_W    = 5;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(15);

  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  typedef struct packed {
    logic                       sample_we;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       coef_we;
    logic [IDX_W-1:0]           coef_idx;
    logic signed [SAMPLE_W-1:0] coef_val;
    logic                       shift_en;
    logic [IDX_W-1:0]           rd_idx;
  } tap_ctrl_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> design/fq15_taps.sv
// ----------------------------------------------------------------------------
// fq15_taps
// delay line and coefficient storage with one indexed read port
// ----------------------------------------------------------------------------
`default_nettype none

module fq15_taps (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire fq15_pkg::tap_ctrl_t                 ctrl_i,
  output logic signed [fq15_pkg::SAMPLE_W-1:0]     rd_sample_o,
  output logic signed [fq15_pkg::SAMPLE_W-1:0]     rd_coef_o
);
  import fq15_pkg::*;

  logic signed [SAMPLE_W-1:0] delay_q [TAPS];
  logic signed [SAMPLE_W-1:0] coef_q  [TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        delay_q[i] <= '0;
      end
    end else if (ctrl_i.sample_we) begin
      delay_q[0] <= ctrl_i.sample;
    end else if (ctrl_i.shift_en) begin
      for (int i = 1; i < TAPS; i++) begin
        delay_q[i] <= delay_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (ctrl_i.coef_we) begin
      coef_q[ctrl_i.coef_idx] <= ctrl_i.coef_val;
    end
  end

  assign rd_sample_o = delay_q[ctrl_i.rd_idx];
  assign rd_coef_o   = coef_q[ctrl_i.rd_idx];

endmodule

`default_nettype wire

>>> design/fq15_mac.sv
// ----------------------------------------------------------------------------
// fq15_mac
// shared multiply-accumulate unit, product registered before the wrapping add
// ----------------------------------------------------------------------------
`default_nettype none

module fq15_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire fq15_pkg::mac_ctrl_t                 ctrl_i,
  input  wire logic signed [fq15_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic signed [fq15_pkg::SAMPLE_W-1:0] coef_i,
  output logic        [fq15_pkg::ACC_W-1:0]        acc_o
);
  import fq15_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_q;
  logic                    prod_vld_q;
  logic        [ACC_W-1:0] acc_q;

  // full-width signed product
  assign prod = sample_i * coef_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

>>> design/fir_filter_q15.sv
// ----------------------------------------------------------------------------
// fir_filter_q15
// 32-tap direct-form fir filter on q1.15 samples with one shared mac
// ----------------------------------------------------------------------------
// usage:
//   input items arrive on s_axis; tuser selects filter (0) or coefficient
//   write (1). a coefficient write gives no item.
//   a filter item runs one multiply-accumulate per tap, one tap a cycle
//   through the shared multiplier, then the last add in S_LAST and the result
//   shift and output register load in S_OUT: the result shows on m_axis and
//   s_axis_tready rises in the same cycle, so a new sample is only taken once
//   the result of the last one is loaded.
//   s_axis_tready is low while a sample is in work. if the receiver stalls
//   with a result still held, a finished sum waits in its final state until
//   the output register frees up. cfg_we_i writes the result shift; write it
//   only while idle.
//   reset clears the delay line and all coefficients and sets the shift to
//   15; no item is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_q15 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] sample_in, [20:16] coef_index, [36:21] coef_value, [39:37] zero
  input  wire logic [39:0] s_axis_tdata_i,
  // [0] func
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [15:0] sample_out
  output logic [15:0]      m_axis_tdata_o,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);
  import fq15_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_LAST = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e                     state_q, state_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [SHIFT_W-1:0]         shift_q;
  logic                       out_vld_q;
  logic [SAMPLE_W-1:0]        out_data_q;

  logic                       in_acc;
  logic                       out_free;
  logic                       load_out;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [CIDX_W-1:0]          in_cidx;
  logic signed [SAMPLE_W-1:0] in_cval;

  tap_ctrl_t                  tap_ctrl;
  mac_ctrl_t                  mac_ctrl;
  logic signed [SAMPLE_W-1:0] rd_sample;
  logic signed [SAMPLE_W-1:0] rd_coef;
  logic        [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_sh;

  assign in_sample = s_axis_tdata_i[15:0];
  assign in_cidx   = s_axis_tdata_i[20:16];
  assign in_cval   = s_axis_tdata_i[36:21];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign load_out        = (state_q == S_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser_i == FUNC_FILTER)) begin
          state_d = S_RUN;
          idx_d   = '0;
        end
      end
      S_RUN: begin
        if (idx_q == IDX_W'(TAPS - 1)) begin
          state_d = S_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_LAST: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    tap_ctrl.sample_we = in_acc && (s_axis_tuser_i == FUNC_FILTER);
    tap_ctrl.sample    = in_sample;
    tap_ctrl.coef_we   = in_acc && (s_axis_tuser_i == FUNC_COEF) &&
                         (int'(in_cidx) < TAPS);
    tap_ctrl.coef_idx  = in_cidx[IDX_W-1:0];
    tap_ctrl.coef_val  = in_cval;
    tap_ctrl.shift_en  = (state_q == S_RUN) && (idx_q == IDX_W'(TAPS - 1));
    tap_ctrl.rd_idx    = idx_q;
    mac_ctrl.clear     = tap_ctrl.sample_we;
    mac_ctrl.mul_en    = (state_q == S_RUN);
  end

  fq15_taps u_taps (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tap_ctrl),
    .rd_sample_o (rd_sample),
    .rd_coef_o   (rd_coef)
  );

  fq15_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (rd_sample),
    .coef_i   (rd_coef),
    .acc_o    (acc)
  );

  assign acc_sh = $signed(acc) >>> shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= acc_sh[SAMPLE_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

>>> design/fq15_checker.sv
// ----------------------------------------------------------------------------
// fq15_checker
// port-level checks of the q15 fir filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fq15_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);
  import fq15_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output item changed");

  // a sample item blocks the input while it is in work
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i == FUNC_FILTER) |=> !s_axis_tready_o)
    else $error("input ready during filter run");

  // a coefficient write keeps the input ready
  a_coef_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i == FUNC_COEF) |=> s_axis_tready_o)
    else $error("coefficient write stalled input");

  // no result can appear right after a sample is taken
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser_i == FUNC_FILTER) |=> ##1 !$rose(m_axis_tvalid_o))
    else $error("output item too early");

endmodule

bind fir_filter_q15 fq15_checker u_fq15_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

>>> tb/tb_fir_filter_q15.sv
// ----------------------------------------------------------------------------
// tb_fir_filter_q15
// self-checking bench for the q15 fir filter: a directed table, then random
// phases at several result shifts, with random idling on both streams, one
// long output hold-off, and every output item checked against a predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fir_filter_q15;
  import fq15_pkg::*;

  localparam int LIMIT_CYC = 400000;
  localparam int DRAIN_CYC = 40;
  localparam int IDLE_PCT  = 21;
  localparam int PHASE_N   = 175;
  localparam int HOLD_CYC  = 400;
  localparam int DIR_N     = 23;

  typedef struct packed {
    logic        func;
    logic [15:0] smp;
    logic [4:0]  idx;
    logic [15:0] val;
    logic        typed;
    logic [15:0] res;
  } row_t;

  // rows with a typed result rely on zero or single-tap coefficients
  localparam row_t DIR_TAB [DIR_N] = '{
    '{FUNC_FILTER, 16'h7fff, 5'd0,  16'h0000, 1'b1, 16'h0000},
    '{FUNC_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b1, 16'h0000},
    '{FUNC_FILTER, 16'h0000, 5'd0,  16'h0000, 1'b1, 16'h0000},
    '{FUNC_COEF,   16'h0000, 5'd0,  16'h8000, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b1, 16'h8000},
    '{FUNC_FILTER, 16'h7fff, 5'd0,  16'h0000, 1'b1, 16'h8001},
    '{FUNC_COEF,   16'hffff, 5'd31, 16'h7fff, 1'b0, 16'h0000},
    '{FUNC_COEF,   16'h0000, 5'd1,  16'h8000, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b0, 16'h0000},
    '{FUNC_COEF,   16'h0000, 5'd2,  16'h8000, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b0, 16'h0000},
    '{FUNC_COEF,   16'h0000, 5'd31, 16'h8000, 1'b0, 16'h0000},
    '{FUNC_COEF,   16'h0000, 5'd16, 16'h7fff, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'hffff, 5'd31, 16'hffff, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'h0001, 5'd0,  16'h0000, 1'b0, 16'h0000},
    '{FUNC_COEF,   16'h0000, 5'd0,  16'h0000, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'h1234, 5'd0,  16'h0000, 1'b0, 16'h0000},
    '{FUNC_COEF,   16'h0000, 5'd10, 16'haaaa, 1'b0, 16'h0000},
    '{FUNC_COEF,   16'h0000, 5'd21, 16'h5555, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'h5555, 5'd0,  16'h0000, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'haaaa, 5'd0,  16'h0000, 1'b0, 16'h0000},
    '{FUNC_FILTER, 16'h8000, 5'd0,  16'h0000, 1'b0, 16'h0000}
  };

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic [39:0] s_tdata   = '0;
  logic        s_tuser   = FUNC_FILTER;
  logic        m_tready  = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        row_typed = 1'b0;
  logic [15:0] row_res   = '0;

  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;

  logic [15:0] dline_m [TAPS];
  logic [15:0] coef_m  [TAPS];
  logic [4:0]  shift_m;
  logic [15:0] filtered_q [$];

  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int err_cnt  = 0;
  int cyc_cnt  = 0;

  fir_filter_q15 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [15:0] fir_predict(logic [15:0] smp);
    logic signed [31:0] acc;
    logic signed [31:0] prod;
    logic signed [31:0] shifted;
    acc = '0;
    dline_m[0] = smp;
    for (int i = 0; i < TAPS; i++) begin
      prod = $signed(dline_m[i]) * $signed(coef_m[i]);
      acc  = acc + prod;
    end
    shifted = acc >>> shift_m;
    for (int i = TAPS - 1; i > 0; i--) dline_m[i] = dline_m[i-1];
    return shifted[15:0];
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    for (int i = 0; i < TAPS; i++) begin
      dline_m[i] = '0;
      coef_m[i]  = '0;
    end
    shift_m = SHIFT_RESET;
  end

  // predictor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (filtered_q.size() == 0) begin
          $error("sample_out: unexpected item %h", m_tdata);
          err_cnt++;
        end else if (m_tdata !== filtered_q[0]) begin
          $error("sample_out: expected %h, got %h", filtered_q[0], m_tdata);
          err_cnt++;
          void'(filtered_q.pop_front());
        end else begin
          void'(filtered_q.pop_front());
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_COEF) begin
          if (int'(s_tdata[20:16]) < TAPS) coef_m[s_tdata[20:16]] = s_tdata[36:21];
        end else if (row_typed) begin
          void'(fir_predict(s_tdata[15:0]));
          filtered_q.push_back(row_res);
        end else begin
          filtered_q.push_back(fir_predict(s_tdata[15:0]));
        end
      end
      if (cfg_we) shift_m = cfg_wdata;
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT_CYC) begin
      $display("fir_filter_q15: mismatch");
      $finish;
    end
  end

  // output side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        m_tready  <= 1'b0;
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic drive_item(logic func, logic [36:0] payload, logic typed,
                            logic [15:0] res);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= func;
    s_tdata   <= {3'b000, payload};
    row_typed <= typed;
    row_res   <= res;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  initial begin
    logic [4:0]  shifts [6];
    logic [36:0] payload;
    logic        func;
    int          n;
    shifts = '{5'd0, 5'd31, 5'd7, 5'($urandom), 5'd15, 5'd1};
    n = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_N; r++) begin
      drive_item(DIR_TAB[r].func, {DIR_TAB[r].val, DIR_TAB[r].idx, DIR_TAB[r].smp},
                 DIR_TAB[r].typed, DIR_TAB[r].res);
    end

    for (int p = 0; p < 6; p++) begin
      drain();
      cfg_we    <= 1'b1;
      cfg_wdata <= shifts[p];
      @(negedge clk_i);
      cfg_we    <= 1'b0;
      @(negedge clk_i);
      for (int k = 0; k < PHASE_N; k++) begin
        n++;
        quiet = (n >= 500 && n < 700);
        if (n == 60) hold_req = 1'b1;
        func    = ($urandom_range(99) < 20) ? FUNC_COEF : FUNC_FILTER;
        payload = {16'($urandom), 5'($urandom), 16'($urandom)};
        if (func == FUNC_COEF) payload[36:21] = pick16();
        else payload[15:0] = pick16();
        drive_item(func, payload, 1'b0, 16'h0000);
      end
    end
    quiet = 1'b0;

    drain();
    if (err_cnt == 0) begin
      $display("fir_filter_q15: match");
    end else begin
      $display("fir_filter_q15: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
